// ===== hdl/pid_impedance_pwm_drive_unit_defines.svh =====
// Assertion helpers for the files that check their own logic.
`ifndef PID_IMPEDANCE_PWM_DRIVE_UNIT_DEFINES_SVH
`define PID_IMPEDANCE_PWM_DRIVE_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and held off during reset.
`define PIDPWM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and held off during reset.
`define PIDPWM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pidpwm_pkg.sv =====
`default_nettype none
package pidpwm_pkg;

  // Field and datapath widths.
  localparam int unsigned POS_W          = 24;
  localparam int unsigned NUM_MOTORS_DEF = 3;
  localparam int unsigned ADDR_W         = 5;
  localparam int unsigned SUM_W          = 18;
  localparam int unsigned ERR_W          = POS_W + 1;
  localparam int unsigned DIF_W          = POS_W + 2;
  localparam int unsigned VEL_FRAC       = 16;
  localparam int unsigned DV_W           = ERR_W + VEL_FRAC + 1;
  localparam int unsigned MAG_W          = 50;
  localparam int unsigned GAIN_W         = 32;
  localparam int unsigned CHUNK_W        = 16;
  localparam int unsigned NUM_CHUNKS     = (MAG_W + CHUNK_W - 1) / CHUNK_W;
  localparam int unsigned ACC_W          = NUM_CHUNKS * CHUNK_W + GAIN_W;
  localparam int unsigned TERM_W         = 62;
  localparam int unsigned EFF_W          = 64;
  localparam int unsigned QUO_W          = 7;
  localparam int unsigned NUM_W          = MAG_W + QUO_W;

  // Constants of the control law.
  localparam int          SUM_LIMIT    = 100000;
  localparam logic [GAIN_W-1:0] BOUND_SCALE = 32'd100000;
  localparam logic [GAIN_W-1:0] STIFF_RESET = 32'd167772;
  localparam logic signed [POS_W-1:0] LIMIT_MOTOR0 = 24'sd97000;
  localparam logic signed [POS_W-1:0] LIMIT_OTHER  = 24'sd109000;
  localparam logic [6:0] PWM_FULL = 7'd100;
  localparam logic [6:0] PID_DEAD = 7'd20;
  localparam logic [TERM_W-1:0] TERM_MAX = 62'd1 << 61;

  typedef enum logic [1:0] {
    DIR_UP    = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_BRAKE = 2'd2,
    DIR_NONE  = 2'd3
  } dir_e;

  typedef enum logic [2:0] {
    REG_MODE  = 3'd0,
    REG_PROP  = 3'd1,
    REG_INT   = 3'd2,
    REG_DERIV = 3'd3,
    REG_STIFF = 3'd4,
    REG_DAMP  = 3'd5,
    REG_VEL   = 3'd6
  } reg_e;

  // Product passes: first gain term, second, third (PID only), clamp bound.
  typedef enum logic [1:0] {
    TERM_A     = 2'd0,
    TERM_B     = 2'd1,
    TERM_C     = 2'd2,
    TERM_BOUND = 2'd3
  } term_e;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PREP, ST_LOAD, ST_MUL, ST_CLAMP, ST_SCALE, ST_DIV, ST_FIN
  } state_e;

  typedef struct packed {
    logic [1:0]              motor_index;
    logic signed [POS_W-1:0] measured_position;
    logic signed [POS_W-1:0] target_position;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        motor_echo;
    dir_e              drive_direction;
    logic [6:0]        duty;
    logic signed [7:0] pwm_signed;
    logic              at_limit;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic shr;
  } mul_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage
`default_nettype wire

// ===== hdl/pidpwm_mul.sv =====
`default_nettype none
// Multi-cycle unsigned gain times magnitude, one 32x16 partial product a cycle,
// optionally scaled down by the velocity fraction and saturated at TERM_MAX.
module pidpwm_mul import pidpwm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mul_ctl_t           ctl_i,
  input  logic [GAIN_W-1:0]  gain_i,
  input  logic [MAG_W-1:0]   mag_i,
  output unit_sts_t          sts_o,
  output logic [TERM_W-1:0]  prod_o
);

  localparam int unsigned CNT_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
  localparam int unsigned PAD_W = NUM_CHUNKS * CHUNK_W;

  logic [PAD_W-1:0]          mag_q;
  logic [GAIN_W-1:0]         gain_q;
  logic                      shr_q;
  logic [ACC_W-1:0]          acc_q;
  logic [ACC_W-1:0]          acc_d;
  logic [ACC_W-1:0]          scaled;
  logic [GAIN_W+CHUNK_W-1:0] part;
  logic [TERM_W-1:0]         prod_q;
  logic [TERM_W-1:0]         prod_d;
  logic [CNT_W-1:0]          cnt_q;
  logic                      busy_q;
  logic                      fin_q;
  logic                      done_q;

  // Horner accumulation from the top chunk down.
  assign part  = gain_q * mag_q[PAD_W-1 -: CHUNK_W];
  assign acc_d = (acc_q << CHUNK_W) + ACC_W'(part);

  // Final scaling and saturation.
  assign scaled = shr_q ? (acc_q >> VEL_FRAC) : acc_q;
  assign prod_d = (scaled > ACC_W'(TERM_MAX)) ? TERM_MAX : scaled[TERM_W-1:0];

  // Sequence control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fin_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        fin_q  <= 1'b0;
        cnt_q  <= '0;
      end else if (busy_q) begin
        if (cnt_q == CNT_W'(NUM_CHUNKS - 1)) begin
          busy_q <= 1'b0;
          fin_q  <= 1'b1;
        end else begin
          cnt_q <= cnt_q + 1'b1;
        end
      end else if (fin_q) begin
        fin_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Operand and accumulator registers.
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      mag_q  <= PAD_W'(mag_i);
      gain_q <= gain_i;
      shr_q  <= ctl_i.shr;
      acc_q  <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      mag_q <= mag_q << CHUNK_W;
    end else if (fin_q) begin
      prod_q <= prod_d;
    end
  end

  assign sts_o.busy = busy_q | fin_q;
  assign sts_o.done = done_q;
  assign prod_o     = prod_q;

endmodule
`default_nettype wire

// ===== hdl/pidpwm_div.sv =====
`default_nettype none
// Restoring divider for a quotient known to fit in QUO_W bits, one bit a cycle.
module pidpwm_div import pidpwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [NUM_W-1:0]  num_i,
  input  logic [MAG_W-1:0]  den_i,
  output unit_sts_t         sts_o,
  output logic [QUO_W-1:0]  quo_o
);

  localparam int unsigned STEP_W = $clog2(QUO_W);

  logic [NUM_W-1:0]  rem_q;
  logic [NUM_W-1:0]  rem_d;
  logic [NUM_W-1:0]  trial;
  logic [MAG_W-1:0]  den_q;
  logic [QUO_W-1:0]  quo_q;
  logic [QUO_W-1:0]  quo_d;
  logic [STEP_W-1:0] step_q;
  logic              busy_q;
  logic              done_q;

  // One trial subtraction of the shifted divisor.
  assign trial = NUM_W'(den_q) << step_q;

  always_comb begin
    rem_d = rem_q;
    quo_d = quo_q;
    if (rem_q >= trial) begin
      rem_d         = rem_q - trial;
      quo_d[step_q] = 1'b1;
    end
  end

  // Step counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= STEP_W'(QUO_W - 1);
      end else if (busy_q) begin
        if (step_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q - 1'b1;
        end
      end
    end
  end

  // Remainder and quotient registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i;
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign sts_o.busy = busy_q;
  assign sts_o.done = done_q;
  assign quo_o      = quo_q;

endmodule
`default_nettype wire

// ===== hdl/pid_impedance_pwm_drive_unit.sv =====
// Channel   Direction  Handshake                    Payload
// in        input      in_valid_i / in_ready_o      in_data_i  (in_item_t)
// out       output     out_valid_o / out_ready_i    out_data_o (out_item_t)
// config    input      psel/penable/pwrite, pready  paddr, pwdata, prdata
//
// Each sample passes through the shared multiplier once for each gain product
// (three in PID mode, two in impedance mode), once for the clamp bound and once
// for the duty scale, and the seven-step divider follows. An unknown motor index or
// a zero clamp bound skips the remaining passes. in_ready_o is high only in
// idle; a finished result waits in the output register while the next sample
// is taken. Reset clears all per-motor state and loads the register defaults.
`default_nettype none
`include "pid_impedance_pwm_drive_unit_defines.svh"
module pid_impedance_pwm_drive_unit import pidpwm_pkg::*; #(
  parameter int unsigned NUM_MOTORS = NUM_MOTORS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  localparam int unsigned IDX_W = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
  localparam logic signed [ERR_W:0] SUM_HI = (ERR_W + 1)'(SUM_LIMIT);
  localparam logic signed [ERR_W:0] SUM_LO = -SUM_HI;

  // Configuration registers.
  logic                     mode_q;
  logic [GAIN_W-1:0]        prop_q;
  logic [GAIN_W-1:0]        int_q;
  logic [GAIN_W-1:0]        deriv_q;
  logic [GAIN_W-1:0]        stiff_q;
  logic [GAIN_W-1:0]        damp_q;
  logic signed [31:0]       vel_q;
  logic                     wr_en;
  reg_e                     reg_sel;

  // Per-motor state.
  logic signed [SUM_W-1:0]  esum_q [NUM_MOTORS];
  logic signed [ERR_W-1:0]  lerr_q [NUM_MOTORS];
  logic signed [POS_W-1:0]  lpos_q [NUM_MOTORS];

  // Sequencer and item registers.
  state_e                   state_q;
  state_e                   state_d;
  term_e                    term_q;
  term_e                    term_next;
  in_item_t                 item_q;
  logic [IDX_W-1:0]         idx_q;
  logic                     mvalid_q;
  logic [IDX_W+1:0]         in_mext;
  logic [IDX_W-1:0]         in_idx;
  logic                     in_ok;

  // Sample preparation.
  logic signed [ERR_W-1:0]  e_c;
  logic signed [ERR_W:0]    ssum_c;
  logic signed [SUM_W-1:0]  s_c;
  logic signed [DIF_W-1:0]  d_c;
  logic signed [ERR_W-1:0]  v_c;
  logic signed [DV_W-1:0]   dv_c;
  logic signed [ERR_W-1:0]  e_q;
  logic signed [SUM_W-1:0]  s_q;
  logic signed [DIF_W-1:0]  d_q;
  logic signed [DV_W-1:0]   dv_q;

  // Term selection and effort.
  logic [GAIN_W-1:0]        term_gain;
  logic signed [MAG_W:0]    term_val;
  logic                     term_neg;
  logic [MAG_W-1:0]         term_mag;
  logic                     tneg_q;
  logic signed [EFF_W-1:0]  effort_q;
  logic [MAG_W-1:0]         bound_q;
  logic signed [EFF_W-1:0]  bnd_s;
  logic signed [EFF_W-1:0]  eff_clamp;
  logic signed [EFF_W-1:0]  eff_abs;
  logic [MAG_W-1:0]         clamp_mag;
  logic                     pos_q;
  logic [6:0]               zone_c;

  // Shared units.
  mul_ctl_t                 mul_ctl;
  logic [GAIN_W-1:0]        mul_gain;
  logic [MAG_W-1:0]         mul_mag;
  unit_sts_t                mul_sts;
  logic [TERM_W-1:0]        mul_prod;
  logic                     div_start;
  unit_sts_t                div_sts;
  logic [QUO_W-1:0]         div_quo;

  // Result.
  logic [6:0]               pwm_mag;
  logic signed [7:0]        pwm_c;
  logic signed [7:0]        pwm_neg;
  logic signed [7:0]        zone_s;
  logic signed [POS_W-1:0]  lim_c;
  out_item_t                res_c;
  out_item_t                out_q;
  logic                     out_valid_q;
  logic                     out_load;

  // Register writes complete in the access phase.
  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      prop_q  <= '0;
      int_q   <= '0;
      deriv_q <= '0;
      stiff_q <= STIFF_RESET;
      damp_q  <= '0;
      vel_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_MODE:  mode_q  <= pwdata[0];
        REG_PROP:  prop_q  <= pwdata;
        REG_INT:   int_q   <= pwdata;
        REG_DERIV: deriv_q <= pwdata;
        REG_STIFF: stiff_q <= pwdata;
        REG_DAMP:  damp_q  <= pwdata;
        REG_VEL:   vel_q   <= pwdata;
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (reg_sel)
      REG_MODE:  prdata = {31'b0, mode_q};
      REG_PROP:  prdata = prop_q;
      REG_INT:   prdata = int_q;
      REG_DERIV: prdata = deriv_q;
      REG_STIFF: prdata = stiff_q;
      REG_DAMP:  prdata = damp_q;
      REG_VEL:   prdata = vel_q;
      default:   prdata = '0;
    endcase
  end

  // Motor index check on the incoming transfer.
  assign in_mext = (IDX_W + 2)'(in_data_i.motor_index);
  assign in_ok   = 32'(in_data_i.motor_index) < NUM_MOTORS;
  assign in_idx  = in_ok ? in_mext[IDX_W-1:0] : '0;

  // Error, clamped error sum, error change and velocity error.
  assign e_c = {item_q.target_position[POS_W-1], item_q.target_position}
             - {item_q.measured_position[POS_W-1], item_q.measured_position};
  assign ssum_c = {{(ERR_W + 1 - SUM_W){esum_q[idx_q][SUM_W-1]}}, esum_q[idx_q]}
                + {e_c[ERR_W-1], e_c};
  assign d_c = {e_c[ERR_W-1], e_c} - {lerr_q[idx_q][ERR_W-1], lerr_q[idx_q]};
  assign v_c = {item_q.measured_position[POS_W-1], item_q.measured_position}
             - {lpos_q[idx_q][POS_W-1], lpos_q[idx_q]};
  assign dv_c = {v_c[ERR_W-1], v_c, {VEL_FRAC{1'b0}}} - DV_W'(vel_q);

  always_comb begin
    if (ssum_c > SUM_HI) begin
      s_c = SUM_HI[SUM_W-1:0];
    end else if (ssum_c < SUM_LO) begin
      s_c = SUM_LO[SUM_W-1:0];
    end else begin
      s_c = ssum_c[SUM_W-1:0];
    end
  end

  // Per-motor state is updated once per valid sample.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_MOTORS; i++) begin
        esum_q[i] <= '0;
        lerr_q[i] <= '0;
        lpos_q[i] <= '0;
      end
    end else if (state_q == ST_PREP && mvalid_q) begin
      if (!mode_q) begin
        esum_q[idx_q] <= s_c;
        lerr_q[idx_q] <= e_c;
      end else begin
        lpos_q[idx_q] <= item_q.measured_position;
      end
    end
  end

  // Gain and signed operand of the current product pass.
  always_comb begin
    term_gain = '0;
    term_val  = '0;
    if (!mode_q) begin
      case (term_q)
        TERM_A: begin
          term_gain = prop_q;
          term_val  = (MAG_W + 1)'(e_q);
        end
        TERM_B: begin
          term_gain = int_q;
          term_val  = (MAG_W + 1)'(s_q);
        end
        TERM_C: begin
          term_gain = deriv_q;
          term_val  = (MAG_W + 1)'(d_q);
        end
        default: begin
          term_gain = BOUND_SCALE;
          term_val  = (MAG_W + 1)'({1'b0, prop_q} + {1'b0, int_q});
        end
      endcase
    end else begin
      case (term_q)
        TERM_A: begin
          term_gain = damp_q;
          term_val  = (MAG_W + 1)'(dv_q);
        end
        TERM_B: begin
          term_gain = stiff_q;
          term_val  = (MAG_W + 1)'(e_q);
        end
        default: begin
          term_gain = BOUND_SCALE;
          term_val  = (MAG_W + 1)'({1'b0, stiff_q});
        end
      endcase
    end
  end

  assign term_neg = term_val[MAG_W];
  assign term_mag = term_neg ? MAG_W'(-term_val) : term_val[MAG_W-1:0];

  // Pass order: three gain terms in PID mode, two in impedance mode, then the bound.
  always_comb begin
    case (term_q)
      TERM_A:  term_next = TERM_B;
      TERM_B:  term_next = mode_q ? TERM_BOUND : TERM_C;
      default: term_next = TERM_BOUND;
    endcase
  end

  // Effort clamp and magnitude for the duty scaling pass.
  assign bnd_s     = EFF_W'(bound_q);
  assign eff_clamp = (effort_q > bnd_s) ? bnd_s : ((effort_q < -bnd_s) ? -bnd_s : effort_q);
  assign eff_abs   = (eff_clamp < 0) ? -eff_clamp : eff_clamp;
  assign clamp_mag = eff_abs[MAG_W-1:0];
  assign zone_c    = mode_q ? 7'd0 : PID_DEAD;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_PREP;
      ST_PREP:  state_d = mvalid_q ? ST_LOAD : ST_FIN;
      ST_LOAD:  state_d = ST_MUL;
      ST_MUL: begin
        if (mul_sts.done) state_d = (term_q == TERM_BOUND) ? ST_CLAMP : ST_LOAD;
      end
      ST_CLAMP: state_d = (bound_q == '0) ? ST_FIN : ST_SCALE;
      ST_SCALE: if (mul_sts.done) state_d = ST_DIV;
      ST_DIV:   if (div_sts.done) state_d = ST_FIN;
      ST_FIN:   if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = 1'b0;
    mul_ctl    = '0;
    mul_gain   = '0;
    mul_mag    = '0;
    div_start  = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_LOAD: begin
        mul_ctl.start = 1'b1;
        mul_ctl.shr   = mode_q && (term_q == TERM_A);
        mul_gain      = term_gain;
        mul_mag       = term_mag;
      end
      ST_CLAMP: begin
        mul_ctl.start = (bound_q != '0);
        mul_gain      = GAIN_W'(PWM_FULL - zone_c);
        mul_mag       = clamp_mag;
      end
      ST_SCALE: div_start = mul_sts.done;
      default: ;
    endcase
  end

  assign out_load = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_A;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_PREP) begin
        term_q <= TERM_A;
      end else if (state_q == ST_MUL && mul_sts.done) begin
        term_q <= term_next;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i) begin
      item_q   <= in_data_i;
      idx_q    <= in_idx;
      mvalid_q <= in_ok;
    end
    if (state_q == ST_PREP) begin
      e_q      <= e_c;
      s_q      <= s_c;
      d_q      <= d_c;
      dv_q     <= dv_c;
      effort_q <= '0;
    end
    if (state_q == ST_LOAD) begin
      tneg_q <= term_neg;
    end
    if (state_q == ST_MUL && mul_sts.done) begin
      if (term_q == TERM_BOUND) begin
        bound_q <= mul_prod[MAG_W-1:0];
      end else if (tneg_q) begin
        effort_q <= effort_q - EFF_W'(mul_prod);
      end else begin
        effort_q <= effort_q + EFF_W'(mul_prod);
      end
    end
    if (state_q == ST_CLAMP) begin
      pos_q <= (eff_clamp > 0);
    end
    if (out_load) begin
      out_q <= res_c;
    end
  end

  pidpwm_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mul_ctl),
    .gain_i (mul_gain),
    .mag_i  (mul_mag),
    .sts_o  (mul_sts),
    .prod_o (mul_prod)
  );

  pidpwm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (mul_prod[NUM_W-1:0]),
    .den_i   (bound_q),
    .sts_o   (div_sts),
    .quo_o   (div_quo)
  );

  // Signed PWM value, direction and the position limit on upward drive.
  assign pwm_mag = zone_c + div_quo;
  assign pwm_c   = (bound_q == '0) ? 8'sd0
                 : (pos_q ? $signed({1'b0, pwm_mag}) : -$signed({1'b0, pwm_mag}));
  assign pwm_neg = -pwm_c;
  assign zone_s  = $signed({1'b0, zone_c});
  assign lim_c   = (item_q.motor_index == 2'd0) ? LIMIT_MOTOR0 : LIMIT_OTHER;

  always_comb begin
    res_c                 = '0;
    res_c.motor_echo      = item_q.motor_index;
    res_c.drive_direction = DIR_NONE;
    if (mvalid_q) begin
      res_c.pwm_signed = pwm_c;
      if (pwm_c > zone_s) begin
        if (item_q.measured_position >= lim_c) begin
          res_c.at_limit = 1'b1;
        end else begin
          res_c.drive_direction = DIR_UP;
          res_c.duty            = pwm_c[6:0];
        end
      end else if (pwm_c < -zone_s) begin
        res_c.drive_direction = DIR_DOWN;
        res_c.duty            = pwm_neg[6:0];
      end else begin
        res_c.drive_direction = mode_q ? DIR_NONE : DIR_BRAKE;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Checks on the sequencer and the result path.
  `PIDPWM_ASSERT_NXT(a_accept_starts_work, in_valid_i && in_ready_o, state_q != ST_IDLE, "transfer accepted but sequencer stayed idle")
  `PIDPWM_ASSERT_IMP(a_limit_blocks_up, out_valid_o && out_data_o.at_limit, out_data_o.drive_direction == DIR_NONE && out_data_o.duty == 7'd0, "limit flag with drive active")
  `PIDPWM_ASSERT_IMP(a_quotient_range, div_sts.done, div_quo <= PWM_FULL, "duty quotient above full scale")

endmodule
`default_nettype wire
